// File: sv/cmc_pkg.sv
// Shared types and constants for the coin match countdown block.
// No dependencies; imported by every cmc_* module and the top level.
package cmc_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int DIA_W     = 15;
    localparam int WEIGHT_W  = 8;
    localparam int MIN_W     = 12;
    localparam int SEC_W     = 6;
    localparam int TOL_RESET = 10;

    localparam logic [SEC_W-1:0] SEC_TOP = 6'd59;
    localparam logic [MIN_W-1:0] MIN_MAX = 12'd4095;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_COIN  = 2'd1;
    localparam logic [1:0] OP_CAL   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [2:0] STAT_NONE     = 3'd0;
    localparam logic [2:0] STAT_ACCEPTED = 3'd1;
    localparam logic [2:0] STAT_INVALID  = 3'd2;
    localparam logic [2:0] STAT_SAVED    = 3'd3;
    localparam logic [2:0] STAT_CLEARED  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP,
        ST_APPLY,
        ST_DONE
    } t_state;

    // diameter kept as mm*100+frac
    typedef struct packed {
        logic [DIA_W-1:0]    dia;
        logic [WEIGHT_W-1:0] weight;
    } t_slot_entry;

    typedef struct packed {
        logic tick;
        logic add;
    } t_tmr_cmd;

endpackage

// File: sv/cmc_slot_mem.sv
// Calibration table: one-write, one-read synchronous memory with registered read.
// Per-entry valid bits make unwritten entries read as zero. Uses cmc_pkg.
module cmc_slot_mem #(
    parameter int SLOTS = cmc_pkg::SLOTS_DEF,
    parameter int AW    = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  cmc_pkg::t_slot_entry i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output cmc_pkg::t_slot_entry o_rd_data
);
    import cmc_pkg::*;

    t_slot_entry             r_mem [SLOTS];
    logic        [SLOTS-1:0] r_vld;
    t_slot_entry             r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/cmc_timer.sv
// Minutes:seconds countdown with saturating credit.
// Driven by a t_tmr_cmd from the sequencer. Uses cmc_pkg.
module cmc_timer #(
    parameter int CRW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cmc_pkg::t_tmr_cmd         i_cmd,
    input  logic [CRW-1:0]            i_credit,
    output logic [cmc_pkg::MIN_W-1:0] o_minutes,
    output logic [cmc_pkg::SEC_W-1:0] o_seconds
);
    import cmc_pkg::*;

    logic [MIN_W-1:0] r_min, n_min;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [MIN_W:0]   sum;

    always_comb begin
        n_min = r_min;
        n_sec = r_sec;
        sum   = (MIN_W+1)'(r_min) + (MIN_W+1)'(i_credit);
        if (i_cmd.tick) begin
            if (r_sec != '0) begin
                n_sec = r_sec - 1'b1;
            end else if (r_min != '0) begin
                n_min = r_min - 1'b1;
                n_sec = SEC_TOP;
            end
        end else if (i_cmd.add) begin
            n_min = (sum > (MIN_W+1)'(MIN_MAX)) ? MIN_MAX : sum[MIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_sec <= '0;
        end else begin
            r_min <= n_min;
            r_sec <= n_sec;
        end
    end

    assign o_minutes = r_min;
    assign o_seconds = r_sec;

endmodule

// File: sv/cmc_seq.sv
// Sequencer: accepts items, walks the table one slot a cycle, drives memory
// writes and timer commands, holds the result register. Uses cmc_pkg.
module cmc_seq #(
    parameter int SLOTS = cmc_pkg::SLOTS_DEF,
    parameter int AW    = 3,
    parameter int CRW   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_diameter_mm,
    input  logic [6:0]                   i_diameter_frac,
    input  logic [cmc_pkg::WEIGHT_W-1:0] i_coin_weight,
    input  logic [2:0]                   i_slot,
    input  logic                         i_timing_valid,
    output logic                         o_mem_wr_en,
    output logic [AW-1:0]                o_mem_wr_addr,
    output cmc_pkg::t_slot_entry         o_mem_wr_data,
    output logic                         o_mem_rd_en,
    output logic [AW-1:0]                o_mem_rd_addr,
    input  cmc_pkg::t_slot_entry         i_mem_rd_data,
    output cmc_pkg::t_tmr_cmd            o_tmr_cmd,
    output logic [CRW-1:0]               o_credit,
    input  logic [cmc_pkg::MIN_W-1:0]    i_minutes,
    input  logic [cmc_pkg::SEC_W-1:0]    i_seconds,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_minutes_added,
    output logic [cmc_pkg::MIN_W-1:0]    o_minutes_remaining,
    output logic [cmc_pkg::SEC_W-1:0]    o_seconds_remaining,
    output logic                         o_timer_active
);
    import cmc_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [AW-1:0]       r_slot, n_slot;
    logic [DIA_W-1:0]    r_dia, n_dia;
    logic [WEIGHT_W-1:0] r_weight, n_weight;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CRW-1:0]      r_inc, n_inc;
    logic [CRW-1:0]      r_credit, n_credit;
    logic                r_hit, n_hit;
    logic [2:0]          r_res, n_res;
    logic [7:0]          r_tol;

    logic                r_out_vld, n_out_vld;
    logic [2:0]          r_status;
    logic [7:0]          r_added;
    logic [MIN_W-1:0]    r_min_o;
    logic [SEC_W-1:0]    r_sec_o;
    logic                r_active;

    logic                accept;
    logic                slot_ok;
    logic                load_out;
    logic [DIA_W-1:0]    dia_gap;
    logic                match;

    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign slot_ok = int'(i_slot) < SLOTS;

    always_comb begin
        dia_gap = (r_dia >= i_mem_rd_data.dia) ? (r_dia - i_mem_rd_data.dia)
                                               : (i_mem_rd_data.dia - r_dia);
        match   = (dia_gap < DIA_W'(r_tol)) && (r_weight == i_mem_rd_data.weight);
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_slot        = r_slot;
        n_dia         = r_dia;
        n_weight      = r_weight;
        n_idx         = r_idx;
        n_inc         = r_inc;
        n_credit      = r_credit;
        n_hit         = r_hit;
        n_res         = r_res;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = '0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_slot;
        o_mem_wr_data = '0;
        o_tmr_cmd     = '0;
        load_out      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op     = i_op;
                    n_slot   = AW'(i_slot);
                    n_dia    = DIA_W'(i_diameter_mm) * DIA_W'(100)
                               + DIA_W'(i_diameter_frac);
                    n_weight = i_coin_weight;
                    n_idx    = '0;
                    n_inc    = CRW'(1);
                    n_credit = '0;
                    n_hit    = 1'b0;
                    n_res    = STAT_NONE;
                    n_state  = ST_APPLY;
                    case (i_op)
                        OP_TICK: begin
                            n_res = STAT_NONE;
                        end
                        OP_COIN: begin
                            if (i_timing_valid) begin
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = '0;
                                n_state       = ST_SCAN;
                            end else begin
                                n_res = STAT_INVALID;
                            end
                        end
                        OP_CAL: begin
                            if (slot_ok) begin
                                n_res = STAT_SAVED;
                            end
                        end
                        OP_CLEAR: begin
                            if (slot_ok) begin
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = AW'(i_slot);
                                n_state       = ST_LOOKUP;
                            end
                        end
                        default: begin
                            n_res = STAT_NONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_credit = CRW'(r_credit + r_inc);
                    n_hit    = 1'b1;
                end
                n_inc = CRW'(r_inc + CRW'(5));
                if (r_idx == LAST) begin
                    n_res   = n_hit ? STAT_ACCEPTED : STAT_INVALID;
                    n_state = ST_APPLY;
                end else begin
                    n_idx         = AW'(r_idx + 1'b1);
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = AW'(r_idx + 1'b1);
                end
            end
            ST_LOOKUP: begin
                if (i_mem_rd_data != '0) begin
                    o_mem_wr_en = 1'b1;
                    n_res       = STAT_CLEARED;
                end
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                o_tmr_cmd.tick = (r_op == OP_TICK);
                o_tmr_cmd.add  = (r_op == OP_COIN) && (r_res == STAT_ACCEPTED);
                if ((r_op == OP_CAL) && (r_res == STAT_SAVED)) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_data = '{dia: r_dia, weight: r_weight};
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_vld = load_out || (r_out_vld && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_tol     <= 8'(TOL_RESET);
            r_credit  <= '0;
            r_hit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_credit  <= n_credit;
            r_hit     <= n_hit;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_slot   <= n_slot;
        r_dia    <= n_dia;
        r_weight <= n_weight;
        r_idx    <= n_idx;
        r_inc    <= n_inc;
        r_res    <= n_res;
        if (load_out) begin
            r_status <= r_res;
            r_added  <= (32'(r_credit) > 255) ? 8'hFF : 8'(r_credit);
            r_min_o  <= i_minutes;
            r_sec_o  <= i_seconds;
            r_active <= (i_minutes != '0) || (i_seconds != '0);
        end
    end

    assign o_in_stall          = (r_state != ST_IDLE);
    assign o_credit            = r_credit;
    assign o_out_valid         = r_out_vld;
    assign o_status            = r_status;
    assign o_minutes_added     = r_added;
    assign o_minutes_remaining = r_min_o;
    assign o_seconds_remaining = r_sec_o;
    assign o_timer_active      = r_active;

`ifndef SYNTHESIS
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside done state");

    a_credit_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit |-> (r_credit == '0))
        else $error("credit without a matching slot");

    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> (r_state == ST_APPLY || r_state == ST_LOOKUP))
        else $error("table write outside apply or lookup");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_SCAN || r_state == ST_LOOKUP || r_state == ST_APPLY))
        else $error("accepted transfer not taken up");

    a_scan_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx != LAST) |=> (r_state == ST_SCAN && r_idx != '0))
        else $error("table scan cut short");
`endif

endmodule

// File: sv/coin_match_countdown.sv
// Top level of the coin match countdown block.
// Instantiates cmc_seq, cmc_slot_mem and cmc_timer; uses cmc_pkg.
//
// Coin acceptor with a SLOTS-entry calibration table and a minutes:seconds
// countdown. One item is processed at a time: a coin with drop timing passes
// scan (one table read per cycle through the single memory read port), apply
// and done; a clear of a slot inside the table passes lookup, apply and done;
// every other item apply and done. A finished result sits in an output register,
// so the next item is taken while it waits. The user must write the tolerance
// register only while no item is in flight; the block does not enforce it.
module coin_match_countdown #(
    parameter int SLOTS = cmc_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_diameter_mm,
    input  logic [6:0]                   i_diameter_frac,
    input  logic [cmc_pkg::WEIGHT_W-1:0] i_coin_weight,
    input  logic [2:0]                   i_slot,
    input  logic                         i_timing_valid,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_status,
    output logic [7:0]                   o_minutes_added,
    output logic [cmc_pkg::MIN_W-1:0]    o_minutes_remaining,
    output logic [cmc_pkg::SEC_W-1:0]    o_seconds_remaining,
    output logic                         o_timer_active
);
    import cmc_pkg::*;

    localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CREDIT_MAX = 5 * SLOTS * (SLOTS - 1) / 2 + SLOTS;
    localparam int CRW        = $clog2(CREDIT_MAX + 1);

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    t_slot_entry      mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    t_slot_entry      mem_rd_data;
    t_tmr_cmd         tmr_cmd;
    logic [CRW-1:0]   credit;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;

    cmc_seq #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .CRW   (CRW)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_op                (i_op),
        .i_diameter_mm       (i_diameter_mm),
        .i_diameter_frac     (i_diameter_frac),
        .i_coin_weight       (i_coin_weight),
        .i_slot              (i_slot),
        .i_timing_valid      (i_timing_valid),
        .o_mem_wr_en         (mem_wr_en),
        .o_mem_wr_addr       (mem_wr_addr),
        .o_mem_wr_data       (mem_wr_data),
        .o_mem_rd_en         (mem_rd_en),
        .o_mem_rd_addr       (mem_rd_addr),
        .i_mem_rd_data       (mem_rd_data),
        .o_tmr_cmd           (tmr_cmd),
        .o_credit            (credit),
        .i_minutes           (minutes),
        .i_seconds           (seconds),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_minutes_added     (o_minutes_added),
        .o_minutes_remaining (o_minutes_remaining),
        .o_seconds_remaining (o_seconds_remaining),
        .o_timer_active      (o_timer_active)
    );

    cmc_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    cmc_timer #(
        .CRW (CRW)
    ) u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (tmr_cmd),
        .i_credit  (credit),
        .o_minutes (minutes),
        .o_seconds (seconds)
    );

endmodule
